// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk, with or without the rst_n qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RCMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RCMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCMS_ASSERT(label, prop, msg)
`define RCMS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ----- hdl/rcms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcms_pkg
// Types, codes and reset values of the robot command and mode sequencer.
// ----------------------------------------------------------------------------
package rcms_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 3;

  typedef enum logic [3:0] {
    M_WAIT     = 4'd0,
    M_APPROACH = 4'd1,
    M_RETREAT  = 4'd2,
    M_SPINR    = 4'd3,
    M_SPINL    = 4'd4,
    M_LEFT     = 4'd5,
    M_RIGHT    = 4'd6,
    M_RESPRAY  = 4'd7,
    M_PAINT    = 4'd8,
    M_STOP     = 4'd9,
    M_PUMPON   = 4'd10,
    M_PUMPOFF  = 4'd11,
    M_CHECK    = 4'd12,
    M_SERVO    = 4'd13,
    M_BEEP     = 4'd14,
    M_NONE     = 4'd15
  } mode_t;

  typedef enum logic [3:0] {
    MC_NONE      = 4'd0,
    MC_APPROACH  = 4'd1,
    MC_RETREAT   = 4'd2,
    MC_SPINR     = 4'd3,
    MC_SPINL     = 4'd4,
    MC_LEFT      = 4'd5,
    MC_RIGHT     = 4'd6,
    MC_FLAT_FWD  = 4'd7,
    MC_FWD       = 4'd8,
    MC_TURN_R    = 4'd9,
    MC_SOFT_STOP = 4'd10
  } motor_cmd_t;

  typedef enum logic [1:0] {
    SP_NONE = 2'd0,
    SP_UP   = 2'd1,
    SP_DOWN = 2'd2
  } speed_t;

  typedef enum logic [1:0] {
    SV_NONE       = 2'd0,
    SV_CLOSE_SLOW = 2'd1,
    SV_OPEN       = 2'd2,
    SV_CLOSE      = 2'd3
  } servo_cmd_t;

  typedef enum logic [3:0] {
    PP_IDLE  = 4'd0,
    PP_EDGE1 = 4'd1,
    PP_TURN1 = 4'd2,
    PP_EDGE2 = 4'd3,
    PP_TURN2 = 4'd4,
    PP_EDGE3 = 4'd5,
    PP_TURN3 = 4'd6,
    PP_EDGE4 = 4'd7,
    PP_DONE  = 4'd8
  } paint_phase_t;

  typedef enum logic [1:0] {
    CK_START   = 2'd0,
    CK_OPENING = 2'd1,
    CK_FWD     = 2'd2,
    CK_CLOSING = 2'd3
  } check_phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JOG_TIMEOUT = 3'd0,
    CFG_BEEP        = 3'd1,
    CFG_LONG_EDGE   = 3'd2,
    CFG_SHORT_EDGE  = 3'd3,
    CFG_TURN        = 3'd4,
    CFG_RESPRAY     = 3'd5,
    CFG_SELFCHECK   = 3'd6
  } cfg_idx_t;

  localparam logic [7:0] KEY_W     = 8'h57;
  localparam logic [7:0] KEY_K     = 8'h4B;
  localparam logic [7:0] KEY_G     = 8'h47;
  localparam logic [7:0] KEY_D     = 8'h44;
  localparam logic [7:0] KEY_J     = 8'h4A;
  localparam logic [7:0] KEY_F     = 8'h46;
  localparam logic [7:0] KEY_U     = 8'h55;
  localparam logic [7:0] KEY_R     = 8'h52;
  localparam logic [7:0] KEY_Y     = 8'h59;
  localparam logic [7:0] KEY_Z     = 8'h5A;
  localparam logic [7:0] KEY_A     = 8'h41;
  localparam logic [7:0] KEY_X     = 8'h58;
  localparam logic [7:0] KEY_T     = 8'h54;
  localparam logic [7:0] KEY_P     = 8'h50;
  localparam logic [7:0] KEY_C     = 8'h43;
  localparam logic [7:0] KEY_PLUS  = 8'h2B;
  localparam logic [7:0] KEY_MINUS = 8'h2D;

  localparam logic [CFG_W-1:0] JOG_TIMEOUT_RST = 16'd2000;
  localparam logic [CFG_W-1:0] BEEP_RST        = 16'd2000;
  localparam logic [CFG_W-1:0] LONG_EDGE_RST   = 16'd26500;
  localparam logic [CFG_W-1:0] SHORT_EDGE_RST  = 16'd12500;
  localparam logic [CFG_W-1:0] TURN_RST        = 16'd3000;
  localparam logic [CFG_W-1:0] RESPRAY_RST     = 16'd5000;
  localparam logic [CFG_W-1:0] SELFCHECK_RST   = 16'd2000;

  typedef struct packed {
    logic [CFG_W-1:0] jog_hold_ms;
    logic [CFG_W-1:0] beep_ms;
    logic [CFG_W-1:0] long_edge_pulses;
    logic [CFG_W-1:0] short_edge_pulses;
    logic [CFG_W-1:0] turn_pulses;
    logic [CFG_W-1:0] respray_pulses;
    logic [CFG_W-1:0] selfcheck_pulses;
  } cfg_t;

  typedef struct packed {
    mode_t        mode;
    mode_t        entered;
    paint_phase_t paint;
    check_phase_t check;
    logic         pump;
    logic         buzzer;
  } state_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [7:0]  cmd_byte;
    logic        cmd_from_bt;
    logic [31:0] now_ms;
    logic        motors_running;
    logic        servo_a_moving;
    logic        servo_b_moving;
  } in_item_t;

  typedef struct packed {
    logic         echo_valid;
    logic         echo_to_bt;
    logic [7:0]   echo_byte;
    logic         stop_first;
    motor_cmd_t   motor_cmd;
    logic [15:0]  motor_pulses;
    speed_t       speed_step;
    logic         pump_level;
    logic         buzzer_level;
    servo_cmd_t   servo_cmd;
    logic         servo_update;
    mode_t        mode_out;
  } out_item_t;

endpackage

// ----- hdl/rcms_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcms channel interfaces
// Valid/ready channels for loop passes in and per-pass results out.
// ----------------------------------------------------------------------------
interface rcms_in_if;
  logic        valid;
  logic        ready;
  logic        cmd_valid;
  logic [7:0]  cmd_byte;
  logic        cmd_from_bt;
  logic [31:0] now_ms;
  logic        motors_running;
  logic        servo_a_moving;
  logic        servo_b_moving;

  modport source (
    output valid, cmd_valid, cmd_byte, cmd_from_bt, now_ms,
           motors_running, servo_a_moving, servo_b_moving,
    input  ready
  );
  modport sink (
    input  valid, cmd_valid, cmd_byte, cmd_from_bt, now_ms,
           motors_running, servo_a_moving, servo_b_moving,
    output ready
  );
endinterface

interface rcms_out_if;
  logic        valid;
  logic        ready;
  logic        echo_valid;
  logic        echo_to_bt;
  logic [7:0]  echo_byte;
  logic        stop_first;
  logic [3:0]  motor_cmd;
  logic [15:0] motor_pulses;
  logic [1:0]  speed_step;
  logic        pump_level;
  logic        buzzer_level;
  logic [1:0]  servo_cmd;
  logic        servo_update;
  logic [3:0]  mode_out;

  modport source (
    output valid, echo_valid, echo_to_bt, echo_byte, stop_first, motor_cmd,
           motor_pulses, speed_step, pump_level, buzzer_level, servo_cmd,
           servo_update, mode_out,
    input  ready
  );
  modport sink (
    input  valid, echo_valid, echo_to_bt, echo_byte, stop_first, motor_cmd,
           motor_pulses, speed_step, pump_level, buzzer_level, servo_cmd,
           servo_update, mode_out,
    output ready
  );
endinterface

// ----- hdl/rcms_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcms_step
// One control-loop pass: command decode, mode entry or periodic step.
// ----------------------------------------------------------------------------
module rcms_step
  import rcms_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  state_t               st,
  input  logic [TIME_BITS-1:0] mode_time,
  input  cfg_t                 cfg,
  input  in_item_t             item,
  output state_t               st_nxt,
  output logic [TIME_BITS-1:0] mode_time_nxt,
  output out_item_t            res
);

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;
  logic                 smove;
  logic                 mrun;

  assign now_t   = TIME_BITS'(item.now_ms);
  assign smove   = item.servo_a_moving | item.servo_b_moving;
  assign mrun    = item.motors_running;

  always_comb begin
    st_nxt        = st;
    mode_time_nxt = mode_time;
    res           = '0;

    if (item.cmd_valid) begin
      res.echo_valid = 1'b1;
      res.echo_to_bt = item.cmd_from_bt;
      res.echo_byte  = item.cmd_byte;
      unique case (item.cmd_byte)
        KEY_W: begin
          res.stop_first = 1'b1;
          st_nxt.mode    = M_WAIT;
        end
        KEY_K: st_nxt.mode = M_PUMPON;
        KEY_G: st_nxt.mode = M_PUMPOFF;
        KEY_D: st_nxt.mode = M_CHECK;
        KEY_J: st_nxt.mode = M_SERVO;
        KEY_F: st_nxt.mode = M_BEEP;
        KEY_U: begin
          st_nxt.mode   = M_APPROACH;
          mode_time_nxt = now_t;
        end
        KEY_R: begin
          st_nxt.mode   = M_RETREAT;
          mode_time_nxt = now_t;
        end
        KEY_Y: begin
          st_nxt.mode   = M_SPINR;
          mode_time_nxt = now_t;
        end
        KEY_Z: begin
          st_nxt.mode   = M_SPINL;
          mode_time_nxt = now_t;
        end
        KEY_A: begin
          st_nxt.mode   = M_LEFT;
          mode_time_nxt = now_t;
        end
        KEY_X: begin
          st_nxt.mode   = M_RIGHT;
          mode_time_nxt = now_t;
        end
        KEY_T: st_nxt.mode = M_STOP;
        KEY_P: st_nxt.mode = M_PAINT;
        KEY_C: begin
          if (st.mode == M_WAIT) st_nxt.mode = M_RESPRAY;
        end
        KEY_PLUS: begin
          if (item.cmd_from_bt) res.speed_step = SP_UP;
        end
        KEY_MINUS: begin
          if (item.cmd_from_bt) res.speed_step = SP_DOWN;
        end
        default: ;
      endcase
    end

    elapsed = now_t - mode_time_nxt;

    if (st_nxt.mode != st.entered) begin
      res.stop_first = 1'b1;
      st_nxt.pump    = 1'b0;
      st_nxt.buzzer  = 1'b0;
      mode_time_nxt  = now_t;
      st_nxt.entered = st_nxt.mode;
      unique case (st_nxt.mode) inside
        M_APPROACH, M_RETREAT, M_SPINR, M_SPINL, M_LEFT, M_RIGHT: begin
          res.motor_cmd = motor_cmd_t'(st_nxt.mode);
        end
        M_RESPRAY: begin
          st_nxt.pump      = 1'b1;
          res.motor_cmd    = MC_FLAT_FWD;
          res.motor_pulses = cfg.respray_pulses;
        end
        M_PAINT: begin
          st_nxt.pump      = 1'b1;
          res.motor_cmd    = MC_FLAT_FWD;
          res.motor_pulses = cfg.long_edge_pulses;
          st_nxt.paint     = PP_EDGE1;
        end
        M_PUMPON: st_nxt.pump = 1'b1;
        M_CHECK:  st_nxt.check = CK_START;
        M_SERVO:  res.servo_cmd = SV_CLOSE_SLOW;
        M_BEEP:   st_nxt.buzzer = 1'b1;
        default: ;
      endcase
    end else begin
      unique case (st_nxt.mode) inside
        M_SERVO: begin
          res.servo_update = 1'b1;
          if (!smove) st_nxt.mode = M_WAIT;
        end
        M_CHECK: begin
          case (st.check)
            CK_START: begin
              res.servo_cmd = SV_OPEN;
              st_nxt.check  = CK_OPENING;
            end
            CK_OPENING: begin
              res.servo_update = 1'b1;
              if (!smove) begin
                res.motor_cmd    = MC_FWD;
                res.motor_pulses = cfg.selfcheck_pulses;
                st_nxt.check     = CK_FWD;
              end
            end
            CK_FWD: begin
              if (!mrun) begin
                res.servo_cmd = SV_CLOSE;
                st_nxt.check  = CK_CLOSING;
              end
            end
            default: begin
              res.servo_update = 1'b1;
              if (!smove) st_nxt.mode = M_WAIT;
            end
          endcase
        end
        M_BEEP: begin
          if (elapsed > TIME_BITS'(cfg.beep_ms)) begin
            st_nxt.buzzer = 1'b0;
            st_nxt.mode   = M_WAIT;
          end
        end
        M_RESPRAY: begin
          if (!mrun) begin
            st_nxt.pump = 1'b0;
            st_nxt.mode = M_WAIT;
          end
        end
        M_PAINT: begin
          if (!mrun) begin
            case (st.paint) inside
              PP_EDGE1, PP_EDGE2, PP_EDGE3: begin
                st_nxt.pump      = 1'b0;
                res.motor_cmd    = MC_TURN_R;
                res.motor_pulses = cfg.turn_pulses;
                st_nxt.paint     = paint_phase_t'(st.paint + 4'd1);
              end
              PP_TURN1, PP_TURN3: begin
                st_nxt.pump      = 1'b1;
                res.motor_cmd    = MC_FLAT_FWD;
                res.motor_pulses = cfg.short_edge_pulses;
                st_nxt.paint     = paint_phase_t'(st.paint + 4'd1);
              end
              PP_TURN2: begin
                st_nxt.pump      = 1'b1;
                res.motor_cmd    = MC_FLAT_FWD;
                res.motor_pulses = cfg.long_edge_pulses;
                st_nxt.paint     = PP_EDGE3;
              end
              PP_EDGE4: begin
                st_nxt.pump  = 1'b0;
                st_nxt.paint = PP_DONE;
                st_nxt.mode  = M_WAIT;
              end
              default: ;
            endcase
          end
        end
        M_APPROACH, M_RETREAT, M_SPINR, M_SPINL, M_LEFT, M_RIGHT: begin
          if (elapsed > TIME_BITS'(cfg.jog_hold_ms)) res.motor_cmd = MC_SOFT_STOP;
          if (!mrun) st_nxt.mode = M_WAIT;
        end
        default: ;
      endcase
    end

    res.pump_level   = st_nxt.pump;
    res.buzzer_level = st_nxt.buzzer;
    res.mode_out     = st_nxt.mode;
  end

endmodule

// ----- hdl/robot_command_mode_sequencer.sv -----
// ----------------------------------------------------------------------------
// robot_command_mode_sequencer
// A pass waits in the input register until the result register is empty or
// out_chan.ready is high, then moves into the result register.
// Throughput: one pass per cycle while out_chan.ready holds; the mode state
// updates in the same cycle a pass moves into the result register.
// Reset (rst_n low, synchronous): mode wait, no mode entered, pump and buzzer
// off, configuration back to defaults, both pipeline registers empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module robot_command_mode_sequencer
  import rcms_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rcms_in_if.sink              in_chan,
  rcms_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic                 in_v_r;
  in_item_t             in_r;
  logic                 out_v_r;
  out_item_t            out_r;
  state_t               st_r;
  state_t               st_nxt;
  logic [TIME_BITS-1:0] mode_time_r;
  logic [TIME_BITS-1:0] mode_time_nxt;
  cfg_t                 cfg_r;
  out_item_t            res;
  logic                 adv;
  logic                 in_xfer;

  assign adv           = in_v_r & (~out_v_r | out_chan.ready);
  assign in_chan.ready = ~in_v_r | adv;
  assign in_xfer       = in_chan.valid & in_chan.ready;

  rcms_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .st            (st_r),
    .mode_time     (mode_time_r),
    .cfg           (cfg_r),
    .item          (in_r),
    .st_nxt        (st_nxt),
    .mode_time_nxt (mode_time_nxt),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      st_r        <= '{mode: M_WAIT, entered: M_NONE, paint: PP_IDLE,
                       check: CK_START, pump: 1'b0, buzzer: 1'b0};
      mode_time_r <= '0;
      cfg_r       <= '{jog_hold_ms: JOG_TIMEOUT_RST, beep_ms: BEEP_RST,
                       long_edge_pulses: LONG_EDGE_RST,
                       short_edge_pulses: SHORT_EDGE_RST, turn_pulses: TURN_RST,
                       respray_pulses: RESPRAY_RST, selfcheck_pulses: SELFCHECK_RST};
    end else begin
      if (in_chan.ready) in_v_r <= in_chan.valid;
      if (adv) begin
        out_v_r     <= 1'b1;
        st_r        <= st_nxt;
        mode_time_r <= mode_time_nxt;
      end else if (out_chan.ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_JOG_TIMEOUT: cfg_r.jog_hold_ms       <= cfg_data;
          CFG_BEEP:        cfg_r.beep_ms           <= cfg_data;
          CFG_LONG_EDGE:   cfg_r.long_edge_pulses  <= cfg_data;
          CFG_SHORT_EDGE:  cfg_r.short_edge_pulses <= cfg_data;
          CFG_TURN:        cfg_r.turn_pulses       <= cfg_data;
          CFG_RESPRAY:     cfg_r.respray_pulses    <= cfg_data;
          CFG_SELFCHECK:   cfg_r.selfcheck_pulses  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_r.cmd_valid      <= in_chan.cmd_valid;
      in_r.cmd_byte       <= in_chan.cmd_byte;
      in_r.cmd_from_bt    <= in_chan.cmd_from_bt;
      in_r.now_ms         <= in_chan.now_ms;
      in_r.motors_running <= in_chan.motors_running;
      in_r.servo_a_moving <= in_chan.servo_a_moving;
      in_r.servo_b_moving <= in_chan.servo_b_moving;
    end
    if (adv) out_r <= res;
  end

  assign out_chan.valid        = out_v_r;
  assign out_chan.echo_valid   = out_r.echo_valid;
  assign out_chan.echo_to_bt   = out_r.echo_to_bt;
  assign out_chan.echo_byte    = out_r.echo_byte;
  assign out_chan.stop_first   = out_r.stop_first;
  assign out_chan.motor_cmd    = out_r.motor_cmd;
  assign out_chan.motor_pulses = out_r.motor_pulses;
  assign out_chan.speed_step   = out_r.speed_step;
  assign out_chan.pump_level   = out_r.pump_level;
  assign out_chan.buzzer_level = out_r.buzzer_level;
  assign out_chan.servo_cmd    = out_r.servo_cmd;
  assign out_chan.servo_update = out_r.servo_update;
  assign out_chan.mode_out     = out_r.mode_out;

  `RCMS_ASSERT(a_stall_holds, (in_v_r && !adv) |=> in_v_r, "stalled pass dropped")
  `RCMS_ASSERT(a_entered_set, $past(rst_n && adv) |-> (st_r.entered != M_NONE), "no entry")
  `RCMS_ASSERT(a_mode_out_match, $past(rst_n && adv) |-> (out_r.mode_out == st_r.mode), "mode")
  `RCMS_ASSERT(a_echo_clear, (out_v_r && !out_r.echo_valid) |-> ({out_r.echo_to_bt, out_r.echo_byte} == 9'd0), "echo")

endmodule
